### hdl/rua_pkg.sv
// Shared types, codes and constants of the resource unit allocator.
package rua_pkg;

  localparam int DEF_MAX_TASKS     = 16;
  localparam int DEF_NUM_RESOURCES = 4;

  localparam int REQ_TYPE_W   = 3;
  localparam int TASK_ID_W    = 4;
  localparam int RES_ID_W     = 2;
  localparam int UNIT_W       = 8;
  localparam int CODE_W       = 3;
  localparam int STATE_W      = 3;
  localparam int TASK_COUNT_W = 5;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 8;

  localparam logic [REQ_TYPE_W-1:0] OP_INIT      = 3'd0;
  localparam logic [REQ_TYPE_W-1:0] OP_REQUEST   = 3'd1;
  localparam logic [REQ_TYPE_W-1:0] OP_RELEASE   = 3'd2;
  localparam logic [REQ_TYPE_W-1:0] OP_TERMINATE = 3'd3;
  localparam logic [REQ_TYPE_W-1:0] OP_CHECK     = 3'd4;

  localparam logic [STATE_W-1:0] TS_NOT_STARTED = 3'd0;
  localparam logic [STATE_W-1:0] TS_COMPUTING   = 3'd1;
  localparam logic [STATE_W-1:0] TS_BLOCKED     = 3'd2;
  localparam logic [STATE_W-1:0] TS_TERMINATED  = 3'd3;
  localparam logic [STATE_W-1:0] TS_ABORTED     = 3'd4;

  localparam logic [CODE_W-1:0] RC_DONE        = 3'd0;
  localparam logic [CODE_W-1:0] RC_BLOCKED     = 3'd1;
  localparam logic [CODE_W-1:0] RC_IGN_ABORTED = 3'd2;
  localparam logic [CODE_W-1:0] RC_TERMINATED  = 3'd3;
  localparam logic [CODE_W-1:0] RC_BAD_RELEASE = 3'd4;
  localparam logic [CODE_W-1:0] RC_DEADLOCK    = 3'd5;
  localparam logic [CODE_W-1:0] RC_NONE        = 3'd6;

  localparam logic [CFG_INDEX_W-1:0] REG_TASK_COUNT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNITS_FIRST = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNITS_LAST  = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SCAN_END,
    S_FREE_RD,
    S_FREE_WR,
    S_RESULT
  } seq_state_t;

  typedef struct packed {
    logic [CODE_W-1:0]    result_code;
    logic [TASK_ID_W-1:0] aborted_task;
    logic [UNIT_W-1:0]    units_free;
  } result_t;

endpackage

### hdl/rua_if.sv
// Handshake channels for requests, results and configuration writes.
interface rua_act_if import rua_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [TASK_ID_W-1:0]  task_id;
  logic [RES_ID_W-1:0]   resource_id;
  logic [UNIT_W-1:0]     unit_count;

  modport source(output valid, req_type, task_id, resource_id, unit_count, input ready);
  modport sink(input valid, req_type, task_id, resource_id, unit_count, output ready);
endinterface

interface rua_rsp_if import rua_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CODE_W-1:0]    result_code;
  logic [TASK_ID_W-1:0] aborted_task;
  logic [UNIT_W-1:0]    units_free;

  modport source(output valid, result_code, aborted_task, units_free, input ready);
  modport sink(input valid, result_code, aborted_task, units_free, output ready);
endinterface

interface rua_cfg_if import rua_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hdl/resource_unit_allocator_core.sv
// Top level of the resource unit allocator: memories, sequencer and result register.
// A terminate also returns the task's held units, one resource after another; a deadlock check
// reads the state of every task in use and, when it aborts a task, returns that task's units.
// One request is in work at a time. Reset starts a clearing pass that zeroes both memories
// first; configuration writes are taken at all times.
module resource_unit_allocator_core import rua_pkg::*; #(
  parameter int MAX_TASKS     = DEF_MAX_TASKS,
  parameter int NUM_RESOURCES = DEF_NUM_RESOURCES
) (
  input  logic    clk,
  input  logic    rst,
  rua_act_if.sink act,
  rua_cfg_if.sink cfg,
  rua_rsp_if.source rsp
);

  localparam int TW  = $clog2(MAX_TASKS);
  localparam int HAW = $clog2(MAX_TASKS * NUM_RESOURCES);

  logic               res_valid;
  logic               res_ready;
  result_t            res;
  logic               ts_we;
  logic [TW-1:0]      ts_waddr;
  logic [STATE_W-1:0] ts_wdata;
  logic               ts_re;
  logic [TW-1:0]      ts_raddr;
  logic [STATE_W-1:0] ts_rdata;
  logic               held_we;
  logic [HAW-1:0]     held_waddr;
  logic [UNIT_W-1:0]  held_wdata;
  logic               held_re;
  logic [HAW-1:0]     held_raddr;
  logic [UNIT_W-1:0]  held_rdata;
  logic               out_valid;
  result_t            out_data;

  rua_seq #(
    .MAX_TASKS    (MAX_TASKS),
    .NUM_RESOURCES(NUM_RESOURCES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .act       (act),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ts_we     (ts_we),
    .ts_waddr  (ts_waddr),
    .ts_wdata  (ts_wdata),
    .ts_re     (ts_re),
    .ts_raddr  (ts_raddr),
    .ts_rdata  (ts_rdata),
    .held_we   (held_we),
    .held_waddr(held_waddr),
    .held_wdata(held_wdata),
    .held_re   (held_re),
    .held_raddr(held_raddr),
    .held_rdata(held_rdata)
  );

  rua_ram #(
    .WIDTH(STATE_W),
    .DEPTH(MAX_TASKS)
  ) u_task_ram (
    .clk  (clk),
    .we   (ts_we),
    .waddr(ts_waddr),
    .wdata(ts_wdata),
    .re   (ts_re),
    .raddr(ts_raddr),
    .rdata(ts_rdata)
  );

  rua_ram #(
    .WIDTH(UNIT_W),
    .DEPTH(MAX_TASKS * NUM_RESOURCES)
  ) u_held_ram (
    .clk  (clk),
    .we   (held_we),
    .waddr(held_waddr),
    .wdata(held_wdata),
    .re   (held_re),
    .raddr(held_raddr),
    .rdata(held_rdata)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_code  = out_data.result_code;
  assign rsp.aborted_task = out_data.aborted_task;
  assign rsp.units_free   = out_data.units_free;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    act.valid && act.ready |=> !act.ready)
    else $error("Allocator accepted a request back to back.");

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !act.ready)
    else $error("Allocator accepted a request while a result was pending.");

  a_aborted_only_on_deadlock: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.result_code != RC_DEADLOCK |-> rsp.aborted_task == '0)
    else $error("Aborted task reported without a broken deadlock.");

endmodule

### hdl/rua_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module rua_ram import rua_pkg::*; #(
  parameter int WIDTH = UNIT_W,
  parameter int DEPTH = DEF_MAX_TASKS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/rua_seq.sv
// Sequencer: configuration, free unit counters and read-modify-write of task and held memories.
module rua_seq import rua_pkg::*; #(
  parameter int MAX_TASKS     = DEF_MAX_TASKS,
  parameter int NUM_RESOURCES = DEF_NUM_RESOURCES,
  localparam int TW  = $clog2(MAX_TASKS),
  localparam int HAW = $clog2(MAX_TASKS * NUM_RESOURCES)
) (
  input  logic               clk,
  input  logic               rst,
  rua_act_if.sink            act,
  rua_cfg_if.sink            cfg,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res,
  output logic               ts_we,
  output logic [TW-1:0]      ts_waddr,
  output logic [STATE_W-1:0] ts_wdata,
  output logic               ts_re,
  output logic [TW-1:0]      ts_raddr,
  input  logic [STATE_W-1:0] ts_rdata,
  output logic               held_we,
  output logic [HAW-1:0]     held_waddr,
  output logic [UNIT_W-1:0]  held_wdata,
  output logic               held_re,
  output logic [HAW-1:0]     held_raddr,
  input  logic [UNIT_W-1:0]  held_rdata
);

  localparam int NW     = $clog2(MAX_TASKS + 1);
  localparam int RW     = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int HDEPTH = MAX_TASKS * NUM_RESOURCES;

  function automatic logic [UNIT_W-1:0] sat_add(input logic [UNIT_W-1:0] a,
                                                input logic [UNIT_W-1:0] b);
    logic [UNIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[UNIT_W] ? '1 : s[UNIT_W-1:0];
  endfunction

  function automatic logic [HAW-1:0] held_addr(input logic [31:0] t, input logic [31:0] r);
    return HAW'(t * NUM_RESOURCES + r);
  endfunction

  seq_state_t state, state_next;

  logic [HAW-1:0]          clr, clr_next;
  logic [REQ_TYPE_W-1:0]   op, op_next;
  logic [TASK_ID_W-1:0]    tid, tid_next;
  logic [RES_ID_W-1:0]     res_id, res_id_next;
  logic [UNIT_W-1:0]       cnt, cnt_next;
  logic [CODE_W-1:0]       code, code_next;
  logic [TASK_ID_W-1:0]    aborted, aborted_next;
  logic [TW-1:0]           victim, victim_next;
  logic [RW-1:0]           ridx, ridx_next;
  logic [NW-1:0]           scan, scan_next;
  logic [TW-1:0]           first, first_next;
  logic                    found, found_next;
  logic                    unblocked, unblocked_next;
  logic [TASK_COUNT_W-1:0] task_count;
  logic [UNIT_W-1:0]       free_units [NUM_RESOURCES];

  logic [NW-1:0]          n;
  logic                   act_fire;
  logic                   cfg_fire;
  logic                   cfg_units;
  logic [CFG_INDEX_W-1:0] cfg_r;
  logic                   in_task_ok;
  logic                   in_res_ok;
  logic                   res_ok;
  logic [RW-1:0]          resx;
  logic [RW-1:0]          fidx;
  logic [UNIT_W-1:0]      fcur;
  logic                   free_we;
  logic [RW-1:0]          free_widx;
  logic [UNIT_W-1:0]      free_wdata;
  logic [HAW-1:0]         haddr;
  logic                   live;

  always_comb begin
    if (task_count == '0) begin
      n = NW'(1);
    end else if (32'(task_count) > MAX_TASKS) begin
      n = NW'(MAX_TASKS);
    end else begin
      n = NW'(task_count);
    end
  end

  assign act.ready  = (state == S_IDLE);
  assign act_fire   = act.valid && act.ready;
  assign cfg.ready  = 1'b1;
  assign cfg_fire   = cfg.valid && cfg.ready;
  assign cfg_units  = cfg_fire && (cfg.index >= REG_UNITS_FIRST) && (cfg.index <= REG_UNITS_LAST);
  assign cfg_r      = cfg.index - REG_UNITS_FIRST;
  assign in_task_ok = 32'(act.task_id) < 32'(n);
  assign in_res_ok  = 32'(act.resource_id) < NUM_RESOURCES;
  assign res_ok     = 32'(res_id) < NUM_RESOURCES;
  assign resx       = res_ok ? RW'(res_id) : '0;
  assign fidx       = (state == S_FREE_WR) ? ridx : resx;
  assign fcur       = free_units[fidx];
  assign haddr      = held_addr(32'(tid), 32'(resx));
  assign live       = (ts_rdata != TS_TERMINATED) && (ts_rdata != TS_ABORTED);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr == HAW'(HDEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (act_fire) begin
          if (act.req_type == OP_CHECK) begin
            state_next = S_SCAN_RD;
          end else if (act.req_type > OP_CHECK || !in_task_ok) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (live && op == OP_TERMINATE) begin
          state_next = S_FREE_RD;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_EV;
      S_SCAN_EV: begin
        if (scan + NW'(1) == n) begin
          state_next = S_SCAN_END;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_END: begin
        if (found && !unblocked) begin
          state_next = S_FREE_RD;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_FREE_RD: state_next = S_FREE_WR;
      S_FREE_WR: begin
        if (ridx == RW'(NUM_RESOURCES - 1)) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_FREE_RD;
        end
      end
      S_RESULT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    clr_next       = clr;
    op_next        = op;
    tid_next       = tid;
    res_id_next    = res_id;
    cnt_next       = cnt;
    code_next      = code;
    aborted_next   = aborted;
    victim_next    = victim;
    ridx_next      = ridx;
    scan_next      = scan;
    first_next     = first;
    found_next     = found;
    unblocked_next = unblocked;
    ts_we          = 1'b0;
    ts_wdata       = TS_NOT_STARTED;
    ts_re          = 1'b0;
    ts_raddr       = TW'(act.task_id);
    held_we        = 1'b0;
    held_waddr     = haddr;
    held_wdata     = '0;
    held_re        = 1'b0;
    held_raddr     = held_addr(32'(act.task_id), in_res_ok ? 32'(act.resource_id) : 32'd0);
    free_we        = 1'b0;
    free_widx      = resx;
    free_wdata     = fcur;
    res_valid      = 1'b0;
    ts_waddr       = TW'(tid);
    unique case (state)
      S_CLEAR: begin
        held_we    = 1'b1;
        held_waddr = clr;
        ts_we      = 32'(clr) < MAX_TASKS;
        ts_waddr   = TW'(clr);
        clr_next   = clr + HAW'(1);
      end
      S_IDLE: begin
        if (act_fire) begin
          op_next        = act.req_type;
          tid_next       = act.task_id;
          res_id_next    = act.resource_id;
          cnt_next       = act.unit_count;
          code_next      = RC_NONE;
          aborted_next   = '0;
          scan_next      = '0;
          ridx_next      = '0;
          found_next     = 1'b0;
          unblocked_next = 1'b0;
          ts_re          = 1'b1;
          held_re        = 1'b1;
        end
      end
      S_CHECK: begin
        if (ts_rdata == TS_TERMINATED) begin
          code_next = RC_TERMINATED;
        end else if (ts_rdata == TS_ABORTED) begin
          code_next = RC_IGN_ABORTED;
        end else begin
          unique case (op)
            OP_INIT: code_next = RC_DONE;
            OP_REQUEST: begin
              if (res_ok) begin
                ts_we = 1'b1;
                if (fcur >= cnt) begin
                  free_we    = 1'b1;
                  free_wdata = fcur - cnt;
                  held_we    = 1'b1;
                  held_wdata = sat_add(held_rdata, cnt);
                  ts_wdata   = TS_COMPUTING;
                  code_next  = RC_DONE;
                end else begin
                  ts_wdata  = TS_BLOCKED;
                  code_next = RC_BLOCKED;
                end
              end
            end
            OP_RELEASE: begin
              if (res_ok) begin
                if (cnt > held_rdata) begin
                  code_next = RC_BAD_RELEASE;
                end else begin
                  held_we    = 1'b1;
                  held_wdata = held_rdata - cnt;
                  free_we    = 1'b1;
                  free_wdata = sat_add(fcur, cnt);
                  code_next  = RC_DONE;
                end
              end
            end
            OP_TERMINATE: begin
              ts_we       = 1'b1;
              ts_wdata    = TS_TERMINATED;
              victim_next = TW'(tid);
              code_next   = RC_DONE;
            end
            default: code_next = RC_NONE;
          endcase
        end
      end
      S_SCAN_RD: begin
        ts_re    = 1'b1;
        ts_raddr = TW'(scan);
      end
      S_SCAN_EV: begin
        if (live) begin
          if (ts_rdata == TS_BLOCKED) begin
            if (!found) begin
              found_next = 1'b1;
              first_next = TW'(scan);
            end
          end else begin
            unblocked_next = 1'b1;
          end
        end
        scan_next = scan + NW'(1);
      end
      S_SCAN_END: begin
        if (found && !unblocked) begin
          ts_we        = 1'b1;
          ts_waddr     = first;
          ts_wdata     = TS_ABORTED;
          victim_next  = first;
          code_next    = RC_DEADLOCK;
          aborted_next = TASK_ID_W'(first);
        end
      end
      S_FREE_RD: begin
        held_re    = 1'b1;
        held_raddr = held_addr(32'(victim), 32'(ridx));
      end
      S_FREE_WR: begin
        free_we    = 1'b1;
        free_widx  = ridx;
        free_wdata = sat_add(fcur, held_rdata);
        held_we    = 1'b1;
        held_waddr = held_addr(32'(victim), 32'(ridx));
        held_wdata = '0;
        ridx_next  = ridx + RW'(1);
      end
      S_RESULT: res_valid = 1'b1;
      default: res_valid = 1'b0;
    endcase
  end

  assign res.result_code  = code;
  assign res.aborted_task = aborted;
  assign res.units_free   = res_ok ? fcur : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      task_count <= TASK_COUNT_W'(1);
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        free_units[i] <= '0;
      end
    end else begin
      state <= state_next;
      clr   <= clr_next;
      if (cfg_fire && cfg.index == REG_TASK_COUNT) begin
        task_count <= cfg.data[TASK_COUNT_W-1:0];
      end
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        if (cfg_units && 32'(cfg_r) == i) begin
          free_units[i] <= cfg.data[UNIT_W-1:0];
        end else if (free_we && free_widx == RW'(i)) begin
          free_units[i] <= free_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    tid       <= tid_next;
    res_id    <= res_id_next;
    cnt       <= cnt_next;
    code      <= code_next;
    aborted   <= aborted_next;
    victim    <= victim_next;
    ridx      <= ridx_next;
    scan      <= scan_next;
    first     <= first_next;
    found     <= found_next;
    unblocked <= unblocked_next;
  end

endmodule

### dv/tb.sv
// Self-checking testbench for resource_unit_allocator_core with its own allocator predictor.
module tb;
  import rua_pkg::*;

  localparam int NTASK         = DEF_MAX_TASKS;
  localparam int NRES          = DEF_NUM_RESOURCES;
  localparam int SETTLE_CYCLES = 2 * NTASK + 2 * NRES + 8;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int PHASE_ITEMS   = 100;

  logic clk;
  logic rst;

  rua_act_if act_if();
  rua_cfg_if cfg_if();
  rua_rsp_if rsp_if();

  resource_unit_allocator_core dut (
    .clk(clk),
    .rst(rst),
    .act(act_if),
    .cfg(cfg_if),
    .rsp(rsp_if)
  );

  logic [TASK_COUNT_W-1:0] task_count_reg;
  logic [UNIT_W-1:0]       free_pool [NRES];
  logic [UNIT_W-1:0]       held_pool [NTASK][NRES];
  logic [STATE_W-1:0]      task_status [NTASK];
  result_t                 pending_results [$];
  int                      mismatch_count = 0;
  int                      send_idle_pct = 0;
  int                      recv_stall_pct = 0;
  int                      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [UNIT_W-1:0] sat_add(logic [UNIT_W-1:0] a, logic [UNIT_W-1:0] b);
    logic [UNIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[UNIT_W] ? {UNIT_W{1'b1}} : s[UNIT_W-1:0];
  endfunction

  function automatic int tasks_in_use();
    int n;
    n = task_count_reg;
    if (n < 1) n = 1;
    if (n > NTASK) n = NTASK;
    return n;
  endfunction

  function automatic bit is_live(int t);
    return task_status[t] != TS_TERMINATED && task_status[t] != TS_ABORTED;
  endfunction

  function automatic int live_below(int n);
    int count;
    count = 0;
    for (int t = 0; t < n; t++) begin
      if (is_live(t)) count++;
    end
    return count;
  endfunction

  // Lowest blocked task when every live task in use is blocked, else -1.
  function automatic int deadlock_victim();
    int live;
    int blocked;
    int first;
    live = 0;
    blocked = 0;
    first = -1;
    for (int t = 0; t < tasks_in_use(); t++) begin
      if (is_live(t)) begin
        live++;
        if (task_status[t] == TS_BLOCKED) begin
          blocked++;
          if (first < 0) first = t;
        end
      end
    end
    return (live != 0 && live == blocked) ? first : -1;
  endfunction

  function automatic void return_all_units(int t);
    for (int r = 0; r < NRES; r++) begin
      free_pool[r] = sat_add(free_pool[r], held_pool[t][r]);
      held_pool[t][r] = '0;
    end
  endfunction

  function automatic result_t allocator_step(logic [REQ_TYPE_W-1:0] op, logic [TASK_ID_W-1:0] tid,
                                             logic [RES_ID_W-1:0] rid, logic [UNIT_W-1:0] cnt);
    result_t res;
    int      victim;
    res.result_code  = RC_NONE;
    res.aborted_task = '0;
    if (op == OP_CHECK) begin
      victim = deadlock_victim();
      if (victim >= 0) begin
        task_status[victim] = TS_ABORTED;
        return_all_units(victim);
        res.result_code  = RC_DEADLOCK;
        res.aborted_task = victim[TASK_ID_W-1:0];
      end
    end else if (op <= OP_TERMINATE && tid < tasks_in_use()) begin
      if (task_status[tid] == TS_TERMINATED) begin
        res.result_code = RC_TERMINATED;
      end else if (task_status[tid] == TS_ABORTED) begin
        res.result_code = RC_IGN_ABORTED;
      end else begin
        case (op)
          OP_INIT: begin
            res.result_code = RC_DONE;
          end
          OP_REQUEST: begin
            if (free_pool[rid] >= cnt) begin
              free_pool[rid] = free_pool[rid] - cnt;
              held_pool[tid][rid] = sat_add(held_pool[tid][rid], cnt);
              task_status[tid] = TS_COMPUTING;
              res.result_code = RC_DONE;
            end else begin
              task_status[tid] = TS_BLOCKED;
              res.result_code = RC_BLOCKED;
            end
          end
          OP_RELEASE: begin
            if (cnt > held_pool[tid][rid]) begin
              res.result_code = RC_BAD_RELEASE;
            end else begin
              held_pool[tid][rid] = held_pool[tid][rid] - cnt;
              free_pool[rid] = sat_add(free_pool[rid], cnt);
              res.result_code = RC_DONE;
            end
          end
          default: begin
            return_all_units(tid);
            task_status[tid] = TS_TERMINATED;
            res.result_code = RC_DONE;
          end
        endcase
      end
    end
    res.units_free = free_pool[rid];
    return res;
  endfunction

  function automatic void apply_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_TASK_COUNT) begin
      task_count_reg = data[TASK_COUNT_W-1:0];
    end else if (idx >= REG_UNITS_FIRST && idx <= REG_UNITS_LAST) begin
      free_pool[idx - REG_UNITS_FIRST] = data;
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_activity(input logic [REQ_TYPE_W-1:0] op, input logic [TASK_ID_W-1:0] tid,
                               input logic [RES_ID_W-1:0] rid, input logic [UNIT_W-1:0] cnt,
                               output result_t predicted);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      act_if.valid <= 1'b0;
      @(negedge clk);
    end
    act_if.valid       <= 1'b1;
    act_if.req_type    <= op;
    act_if.task_id     <= tid;
    act_if.resource_id <= rid;
    act_if.unit_count  <= cnt;
    do @(posedge clk); while (!act_if.ready);
    predicted = allocator_step(op, tid, rid, cnt);
    pending_results.push_back(predicted);
  endtask

  task automatic issue(input logic [REQ_TYPE_W-1:0] op, input logic [TASK_ID_W-1:0] tid,
                       input logic [RES_ID_W-1:0] rid, input logic [UNIT_W-1:0] cnt);
    result_t ignored;
    send_activity(op, tid, rid, cnt, ignored);
  endtask

  // Holds off new requests until every pending result is out and the core is quiet.
  task automatic drain_results();
    @(negedge clk);
    act_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    apply_config(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result code %0d with nothing pending", rsp_if.result_code));
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.result_code !== want.result_code)
          report_mismatch($sformatf("result_code %0d, expected %0d",
                                    rsp_if.result_code, want.result_code));
        if (rsp_if.aborted_task !== want.aborted_task)
          report_mismatch($sformatf("aborted_task %0d, expected %0d",
                                    rsp_if.aborted_task, want.aborted_task));
        if (rsp_if.units_free !== want.units_free)
          report_mismatch($sformatf("units_free %0d, expected %0d",
                                    rsp_if.units_free, want.units_free));
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((act_if.valid && act_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("** resource_unit_allocator_core: FAILED **");
    $finish;
  end

  // With one task in use and no units, a failed request leads straight to an abort.
  task automatic test_reset_defaults();
    issue(OP_INIT, 0, 0, 0);
    issue(OP_REQUEST, 1, 0, 1);
    issue(OP_CHECK + 3, 0, 0, 0);
    issue(OP_REQUEST, 0, 0, 0);
    issue(OP_REQUEST, 0, 1, 255);
    issue(OP_CHECK, 15, 3, 0);
    issue(OP_RELEASE, 0, 0, 0);
    drain_results();
    write_register(REG_TASK_COUNT, 8'hFF);
    write_register(REG_UNITS_FIRST, 8'd255);
    write_register(REG_UNITS_FIRST + 1, 8'd0);
    write_register(REG_UNITS_FIRST + 2, 8'd1);
    write_register(REG_UNITS_LAST, 8'd128);
  endtask

  // Reloading a total under held units drives both saturation paths.
  task automatic test_grants_and_releases();
    issue(OP_REQUEST, 1, 0, 255);
    drain_results();
    write_register(REG_UNITS_FIRST, 8'd255);
    issue(OP_REQUEST, 1, 0, 10);
    issue(OP_RELEASE, 1, 0, 20);
    issue(OP_RELEASE, 1, 0, 255);
    issue(OP_RELEASE, 2, 2, 1);
    issue(OP_INIT, 2, 0, 0);
  endtask

  task automatic test_terminate_and_blocking();
    issue(OP_REQUEST, 2, 2, 1);
    issue(OP_REQUEST, 3, 2, 1);
    issue(OP_CHECK, 0, 2, 0);
    issue(OP_REQUEST, 3, 3, 128);
    issue(OP_TERMINATE, 2, 2, 0);
    issue(OP_TERMINATE, 2, 1, 0);
    issue(OP_REQUEST, 2, 0, 1);
    issue(OP_TERMINATE, 0, 3, 0);
    issue(OP_CHECK + 1, 4, 0, 0);
  endtask

  function automatic logic [CFG_DATA_W-1:0] unit_total_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return $urandom_range(12);
    if (pick < 70) return 8'd255;
    if (pick < 80) return 8'd0;
    return $urandom_range(255);
  endfunction

  // Tasks are never revived, so terminations and aborts are spread over the whole run.
  function automatic bit may_retire(int counted);
    int dead;
    dead = NTASK - live_below(NTASK);
    return dead < 3 + counted / 140 && NTASK - dead > 3;
  endfunction

  task automatic configure_phase(input int phase);
    int                    n;
    logic [CFG_DATA_W-1:0] data;
    n = $urandom_range(NTASK, 1);
    while (n < NTASK && live_below(n) < 2) n++;
    data = $urandom_range(255);
    data[TASK_COUNT_W-1:0] = n[TASK_COUNT_W-1:0];
    if (phase % 7 == 3) data[TASK_COUNT_W-1:0] = '0;
    if (phase % 7 == 5) data[TASK_COUNT_W-1:0] = $urandom_range(31, NTASK + 1);
    write_register(REG_TASK_COUNT, data);
    for (int k = 0; k < NRES; k++) begin
      if (phase == 0 || $urandom_range(99) < 70)
        write_register(REG_UNITS_FIRST + k, unit_total_value());
    end
    if ($urandom_range(99) < 20)
      write_register(REG_UNITS_LAST + 1 + $urandom_range(2), $urandom_range(255));
  endtask

  task automatic pick_activity(input int counted, output logic [REQ_TYPE_W-1:0] op,
                               output logic [TASK_ID_W-1:0] tid, output logic [RES_ID_W-1:0] rid,
                               output logic [UNIT_W-1:0] cnt);
    int n;
    int cands [$];
    int pick;
    int victim;
    int room;
    n = tasks_in_use();
    for (int t = 0; t < n; t++) begin
      if (is_live(t)) cands.push_back(t);
    end
    rid = $urandom_range(NRES - 1);
    cnt = $urandom_range(255);
    if (cands.size() != 0 && $urandom_range(99) < 85) begin
      tid = cands[$urandom_range(cands.size() - 1)];
      pick = $urandom_range(99);
      if (pick < 10) begin
        op = OP_INIT;
      end else if (pick < 50) begin
        op = OP_REQUEST;
        room = free_pool[rid] + 3;
        if (room > 255) room = 255;
        pick = $urandom_range(99);
        if (pick < 10) cnt = '0;
        else if (pick >= 25) cnt = $urandom_range(room);
      end else if (pick < 75) begin
        op = OP_RELEASE;
        if ($urandom_range(99) < 80) cnt = $urandom_range(held_pool[tid][rid]);
      end else if (pick < 80) begin
        op = OP_TERMINATE;
      end else begin
        op = OP_CHECK;
      end
    end else begin
      op  = $urandom_range(7);
      tid = $urandom_range(NTASK - 1);
    end
    victim = deadlock_victim();
    if (!may_retire(counted)) begin
      if (op == OP_CHECK && victim >= 0) begin
        op  = OP_REQUEST;
        tid = victim;
        cnt = '0;
      end else if (op == OP_TERMINATE && tid < n && is_live(tid)) begin
        op = OP_INIT;
      end
    end
  endtask

  task automatic test_random_traffic();
    int                    counted;
    int                    phase;
    int                    sent;
    int                    phase_count;
    result_t               got;
    logic [REQ_TYPE_W-1:0] op;
    logic [TASK_ID_W-1:0]  tid;
    logic [RES_ID_W-1:0]   rid;
    logic [UNIT_W-1:0]     cnt;
    counted = 0;
    phase = 0;
    while (counted < RANDOM_ITEMS && phase < 60) begin
      drain_results();
      configure_phase(phase);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct = 14;
          recv_stall_pct = 14;
        end
      endcase
      sent = 0;
      phase_count = 0;
      while (phase_count < PHASE_ITEMS && sent < 2 * PHASE_ITEMS) begin
        pick_activity(counted, op, tid, rid, cnt);
        send_activity(op, tid, rid, cnt, got);
        sent++;
        if (got.result_code != RC_IGN_ABORTED && got.result_code != RC_TERMINATED &&
            got.result_code != RC_NONE) begin
          phase_count++;
          counted++;
        end
      end
      phase++;
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst                = 1'b1;
    act_if.valid       = 1'b0;
    act_if.req_type    = OP_INIT;
    act_if.task_id     = '0;
    act_if.resource_id = '0;
    act_if.unit_count  = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_TASK_COUNT;
    cfg_if.data        = '0;
    task_count_reg     = 1;
    for (int t = 0; t < NTASK; t++) begin
      task_status[t] = TS_NOT_STARTED;
      for (int r = 0; r < NRES; r++) held_pool[t][r] = '0;
    end
    for (int r = 0; r < NRES; r++) free_pool[r] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_grants_and_releases();
    test_terminate_and_blocking();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0)
      $display("** resource_unit_allocator_core: PASSED **");
    else
      $display("** resource_unit_allocator_core: FAILED **");
    $finish;
  end

endmodule
